// ----- hdl/sbhd_pkg.sv -----
// Shared constants, types and pattern helpers for the smooth-hue demosaic block.
package sbhd_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int PIX_W       = 8;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W     = COL_W + 1;
	localparam int HEIGHT_W    = ROW_W + 1;
	localparam int RING_W      = 2;
	localparam int LINE_ADDR_W = RING_W + COL_W;
	localparam int MIN_SIZE    = 6;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_BAYER_PATTERN = 2'd2
	} cfg_index_t;

	// One request to the hue interpolation unit.
	typedef struct packed {
		logic                  quad;
		logic [PIX_W-1:0]      g;
		logic [3:0][PIX_W-1:0] cv;
		logic [3:0][PIX_W-1:0] gv;
	} hue_req_t;

	// Row parity of the red sites for each colour filter layout.
	function automatic logic red_row_par(input logic [1:0] pattern);
		return (pattern == 2'd1) || (pattern == 2'd3);
	endfunction

	// Column parity of the red sites for each colour filter layout.
	function automatic logic red_col_par(input logic [1:0] pattern);
		return (pattern == 2'd1) || (pattern == 2'd2);
	endfunction

endpackage

// ----- hdl/bayer_smooth_hue_demosaic.sv -----
// Top level of the smooth-hue Bayer demosaic: sequencer, line stores and output register.
// One raw sample is taken per transfer and the block then works on it alone: border
// samples finish at once, a sample that only updates the green store takes five reads
// and a write, and one that produces an interior pixel also takes nine window reads and
// one hue interpolation at red and blue sites and two at green sites. An interpolation
// that ends in the clamp skips the division. The work is bounded by the single read port
// of each line store (fourteen sequential reads per pixel) and by the one shared hue
// unit. A finished pixel waits in the output register, so the next sample is taken at
// once; only when that register still holds the previous pixel as the first
// interpolation is due does the sequencer wait there for its output transfer.
module bayer_smooth_hue_demosaic import sbhd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] raw_pixel
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
	                               // [33:24] out_column, [45:34] out_row, [47:46] zero
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_GRD, S_GCAP, S_GWR, S_WRD, S_WCAP,
		S_HUE1, S_HUE1W, S_HUE2, S_HUE2W
	} state_t;

	state_t                state_q;
	logic [3:0]            k_q;
	logic [ROW_W-1:0]      row_cnt_q;
	logic [COL_W-1:0]      col_cnt_q;
	logic [ROW_W-1:0]      cur_row_q;
	logic [COL_W-1:0]      cur_col_q;
	logic                  do_out_q;
	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [1:0]            pattern_q;
	logic [4:0][PIX_W-1:0] gnb_q;
	logic [8:0][PIX_W-1:0] rw_q;
	logic [8:0][PIX_W-1:0] gw_q;
	logic [PIX_W-1:0]      hue1_q;
	logic [PIX_W-1:0]      red_q;
	logic [PIX_W-1:0]      green_q;
	logic [PIX_W-1:0]      blue_q;
	logic [COL_W-1:0]      ocol_q;
	logic [ROW_W-1:0]      orow_q;
	logic                  oend_q;
	logic                  m_valid_q;

	logic [WIDTH_W-1:0]     w_eff;
	logic [HEIGHT_W-1:0]    h_eff;
	logic                   in_acc;
	logic [ROW_W-1:0]       acc_row;
	logic [COL_W-1:0]       acc_col;
	logic [WIDTH_W-1:0]     col_inc;
	logic [HEIGHT_W-1:0]    row_inc;
	logic                   do_green;
	logic                   do_out;
	logic [1:0]             ro;
	logic [1:0]             co_sub;
	logic [LINE_ADDR_W-1:0] rd_addr;
	logic [LINE_ADDR_W-1:0] raw_waddr;
	logic [LINE_ADDR_W-1:0] grn_waddr;
	logic [PIX_W-1:0]       raw_rdata;
	logic [PIX_W-1:0]       grn_rdata;
	logic [PIX_W+1:0]       gsum;
	logic [PIX_W-1:0]       grn_wdata;
	logic                   grn_we;
	logic                   pr;
	logic                   pc;
	logic                   red_site;
	logic                   blue_site;
	logic                   green_site;
	logic                   out_free;
	logic                   out_load;
	logic                   hue_start;
	hue_req_t               hue_req;
	logic                   hue_done;
	logic [PIX_W-1:0]       hue_result;
	logic [ROW_W-1:0]       out_r;
	logic [COL_W-1:0]       out_c;
	logic                   out_end;

	// Sizes saturated to the supported range.
	always_comb begin
		if (width_q < WIDTH_W'(MIN_SIZE)) begin
			w_eff = WIDTH_W'(MIN_SIZE);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q < HEIGHT_W'(MIN_SIZE)) begin
			h_eff = HEIGHT_W'(MIN_SIZE);
		end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Position of the incoming sample and the work it triggers.
	always_comb begin
		in_acc   = s_tvalid && s_tready;
		acc_row  = s_tuser ? '0 : row_cnt_q;
		acc_col  = s_tuser ? '0 : col_cnt_q;
		col_inc  = WIDTH_W'(acc_col) + WIDTH_W'(1);
		row_inc  = HEIGHT_W'(acc_row) + HEIGHT_W'(1);
		do_green = (acc_row >= ROW_W'(2)) && (acc_col >= COL_W'(2));
		do_out   = (acc_row >= ROW_W'(4)) && (acc_col >= COL_W'(4)) &&
		           (HEIGHT_W'(acc_row) < h_eff) && (WIDTH_W'(acc_col) < w_eff);
	end

	// Read address: ring row offset and column back-off for each read slot.
	always_comb begin
		ro     = 2'd0;
		co_sub = 2'd0;
		if (state_q == S_GRD) begin
			case (k_q)
				4'd0:    begin ro = 2'd3; co_sub = 2'd1; end
				4'd1:    begin ro = 2'd2; co_sub = 2'd1; end
				4'd2:    begin ro = 2'd3; co_sub = 2'd2; end
				4'd3:    begin ro = 2'd3; co_sub = 2'd0; end
				default: begin ro = 2'd0; co_sub = 2'd1; end
			endcase
		end else begin
			case (k_q)
				4'd0:    begin ro = 2'd1; co_sub = 2'd3; end
				4'd1:    begin ro = 2'd1; co_sub = 2'd2; end
				4'd2:    begin ro = 2'd1; co_sub = 2'd1; end
				4'd3:    begin ro = 2'd2; co_sub = 2'd3; end
				4'd4:    begin ro = 2'd2; co_sub = 2'd2; end
				4'd5:    begin ro = 2'd2; co_sub = 2'd1; end
				4'd6:    begin ro = 2'd3; co_sub = 2'd3; end
				4'd7:    begin ro = 2'd3; co_sub = 2'd2; end
				default: begin ro = 2'd3; co_sub = 2'd1; end
			endcase
		end
		rd_addr   = {cur_row_q[1:0] + ro, cur_col_q - COL_W'(co_sub)};
		raw_waddr = {acc_row[1:0], acc_col};
		grn_waddr = {cur_row_q[1:0] + 2'd3, cur_col_q - COL_W'(1)};
	end

	// Green at the pixel one row and one column behind the incoming sample.
	always_comb begin
		pr        = red_row_par(pattern_q);
		pc        = red_col_par(pattern_q);
		gsum      = (PIX_W+2)'(gnb_q[1]) + (PIX_W+2)'(gnb_q[2]) +
		            (PIX_W+2)'(gnb_q[3]) + (PIX_W+2)'(gnb_q[4]);
		grn_wdata = ((cur_row_q[0] ^ cur_col_q[0]) != (pr ^ pc)) ? gnb_q[0] : gsum[PIX_W+1:2];
		grn_we    = (state_q == S_GWR);
	end

	// Site kind of the output pixel and the hue unit request.
	always_comb begin
		red_site   = (cur_row_q[0] == pr) && (cur_col_q[0] == pc);
		blue_site  = (cur_row_q[0] != pr) && (cur_col_q[0] != pc);
		green_site = !red_site && !blue_site;
		// The output register is free when empty or when its pixel leaves this cycle.
		out_free   = !m_valid_q || m_tready;
		out_load   = ((state_q == S_HUE1W) && hue_done && !green_site) ||
		             ((state_q == S_HUE2W) && hue_done);
		hue_start  = ((state_q == S_HUE1) && out_free) || (state_q == S_HUE2);
		hue_req.g  = gw_q[4];
		if (state_q == S_HUE2) begin
			hue_req.quad = 1'b0;
			hue_req.cv   = {PIX_W'(0), PIX_W'(0), rw_q[7], rw_q[1]};
			hue_req.gv   = {PIX_W'(0), PIX_W'(0), gw_q[7], gw_q[1]};
		end else if (green_site) begin
			hue_req.quad = 1'b0;
			hue_req.cv   = {PIX_W'(0), PIX_W'(0), rw_q[5], rw_q[3]};
			hue_req.gv   = {PIX_W'(0), PIX_W'(0), gw_q[5], gw_q[3]};
		end else begin
			hue_req.quad = 1'b1;
			hue_req.cv   = {rw_q[8], rw_q[6], rw_q[2], rw_q[0]};
			hue_req.gv   = {gw_q[8], gw_q[6], gw_q[2], gw_q[0]};
		end
		out_r   = cur_row_q - ROW_W'(2);
		out_c   = cur_col_q - COL_W'(2);
		out_end = (HEIGHT_W'(out_r) == h_eff - HEIGHT_W'(3)) &&
		          (WIDTH_W'(out_c) == w_eff - WIDTH_W'(3));
	end

	sbhd_ram #(.DATA_W(PIX_W), .ADDR_W(LINE_ADDR_W)) u_raw_store (
		.clk   (clk),
		.we    (in_acc),
		.waddr (raw_waddr),
		.wdata (s_tdata),
		.raddr (rd_addr),
		.rdata (raw_rdata)
	);

	sbhd_ram #(.DATA_W(PIX_W), .ADDR_W(LINE_ADDR_W)) u_green_store (
		.clk   (clk),
		.we    (grn_we),
		.waddr (grn_waddr),
		.wdata (grn_wdata),
		.raddr (rd_addr),
		.rdata (grn_rdata)
	);

	sbhd_hue u_hue (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hue_start),
		.req    (hue_req),
		.done   (hue_done),
		.result (hue_result)
	);

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_W'(1024);
			height_q  <= HEIGHT_W'(1024);
			pattern_q <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FRAME_WIDTH:   width_q   <= cfg_data[WIDTH_W-1:0];
				CFG_FRAME_HEIGHT:  height_q  <= cfg_data[HEIGHT_W-1:0];
				CFG_BAYER_PATTERN: pattern_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, position counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			k_q       <= '0;
			row_cnt_q <= '0;
			col_cnt_q <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			do_out_q  <= 1'b0;
			hue1_q    <= '0;
			red_q     <= '0;
			green_q   <= '0;
			blue_q    <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			oend_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cur_row_q <= acc_row;
						cur_col_q <= acc_col;
						do_out_q  <= do_out;
						k_q       <= '0;
						if (col_inc >= w_eff) begin
							col_cnt_q <= '0;
							row_cnt_q <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
						end else begin
							col_cnt_q <= col_inc[COL_W-1:0];
						end
						if (do_green) begin
							state_q <= S_GRD;
						end
					end
				end
				S_GRD: state_q <= S_GCAP;
				S_GCAP: begin
					if (k_q == 4'd4) begin
						state_q <= S_GWR;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= S_GRD;
					end
				end
				S_GWR: begin
					k_q     <= '0;
					state_q <= do_out_q ? S_WRD : S_IDLE;
				end
				S_WRD: state_q <= S_WCAP;
				S_WCAP: begin
					if (k_q == 4'd8) begin
						state_q <= S_HUE1;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= S_WRD;
					end
				end
				// Wait here until the previous pixel has left the output register.
				S_HUE1: begin
					if (out_free) begin
						state_q <= S_HUE1W;
					end
				end
				S_HUE1W: begin
					if (hue_done) begin
						hue1_q <= hue_result;
						ocol_q <= out_c;
						orow_q <= out_r;
						oend_q <= out_end;
						if (green_site) begin
							state_q <= S_HUE2;
						end else begin
							green_q <= gw_q[4];
							red_q   <= red_site ? rw_q[4] : hue_result;
							blue_q  <= red_site ? hue_result : rw_q[4];
							state_q <= S_IDLE;
						end
					end
				end
				S_HUE2: state_q <= S_HUE2W;
				S_HUE2W: begin
					if (hue_done) begin
						green_q <= rw_q[4];
						if (cur_row_q[0] == pr) begin
							red_q  <= hue1_q;
							blue_q <= hue_result;
						end else begin
							red_q  <= hue_result;
							blue_q <= hue1_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Read data capture into the neighbourhood registers.
	always_ff @(posedge clk) begin
		if (state_q == S_GCAP) begin
			gnb_q[k_q[2:0]] <= raw_rdata;
		end
		if (state_q == S_WCAP) begin
			rw_q[k_q] <= raw_rdata;
			gw_q[k_q] <= grn_rdata;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, orow_q, ocol_q, blue_q, green_q, red_q};
	assign m_tlast  = oend_q;

endmodule

// ----- hdl/sbhd_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
module sbhd_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/sbhd_hue.sv -----
// Multi-cycle hue interpolation unit: floor(g * sum(c_i/g_i) / n), clamped to 255.
module sbhd_hue import sbhd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hue_req_t         req,
	output logic             done,
	output logic [PIX_W-1:0] result
);

	typedef enum logic [2:0] {H_IDLE, H_MUL, H_SCALE, H_CLAMP, H_DIV} hstate_t;

	hstate_t               state_q;
	logic [1:0]            i_q;
	logic [1:0]            j_q;
	logic [2:0]            k_q;
	logic                  quad_q;
	logic [PIX_W-1:0]      g_q;
	logic [3:0][PIX_W-1:0] cv_q;
	logic [3:0][PIX_W-1:0] gs_q;
	logic [31:0]           term_q;
	logic [31:0]           prod_q;
	logic [41:0]           num_q;
	logic [33:0]           den_q;
	logic [PIX_W-1:0]      quo_q;

	logic [PIX_W-1:0] mul_op;
	logic [39:0]      term_prod;
	logic [39:0]      prod_prod;
	logic [41:0]      scale_prod;
	logic [41:0]      den_sh;
	logic [41:0]      den_clamp;
	logic             div_ge;
	logic [PIX_W-1:0] quo_next;

	// One term multiply and one denominator multiply per cycle.
	always_comb begin
		mul_op     = (j_q == i_q) ? PIX_W'(1) : gs_q[j_q];
		term_prod  = 40'(term_q) * 40'(mul_op);
		prod_prod  = 40'(prod_q) * 40'(gs_q[j_q]);
		scale_prod = 42'(num_q[33:0]) * 42'(g_q);
		den_sh     = 42'(den_q) << k_q;
		den_clamp  = {den_q, 8'b0};
		div_ge     = (num_q >= den_sh);
		quo_next   = quo_q | (div_ge ? (PIX_W'(1) << k_q) : PIX_W'(0));
	end

	// Sequencer state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) begin
						i_q <= i_q + 2'd1;
						if (i_q == 2'd3) begin
							state_q <= H_SCALE;
						end
					end
				end
				H_SCALE: begin
					state_q <= H_CLAMP;
				end
				H_CLAMP: begin
					if (num_q >= den_clamp) begin
						result  <= '1;
						done    <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						k_q     <= 3'd7;
						state_q <= H_DIV;
					end
				end
				H_DIV: begin
					k_q <= k_q - 3'd1;
					if (k_q == 3'd0) begin
						result  <= quo_next;
						done    <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				if (start) begin
					quad_q <= req.quad;
					g_q    <= req.g;
					for (int s = 0; s < 4; s++) begin
						if (!req.quad && s >= 2) begin
							cv_q[s] <= '0;
							gs_q[s] <= PIX_W'(1);
						end else begin
							cv_q[s] <= req.cv[s];
							gs_q[s] <= (req.gv[s] == '0) ? PIX_W'(1) : req.gv[s];
						end
					end
					term_q <= 32'(req.cv[0]);
					prod_q <= 32'd1;
					num_q  <= '0;
					quo_q  <= '0;
				end
			end
			H_MUL: begin
				term_q <= term_prod[31:0];
				if (i_q == 2'd0) begin
					prod_q <= prod_prod[31:0];
				end
				if (j_q == 2'd3) begin
					num_q  <= num_q + 42'(term_prod[31:0]);
					term_q <= 32'(cv_q[i_q + 2'd1]);
				end
			end
			H_SCALE: begin
				num_q <= scale_prod;
				den_q <= quad_q ? {prod_q, 2'b0} : {1'b0, prod_q, 1'b0};
			end
			H_DIV: begin
				if (div_ge) begin
					num_q <= num_q - den_sh;
				end
				quo_q <= quo_next;
			end
			default: begin
			end
		endcase
	end

endmodule
